>>> hw/rtl/ffpd_pkg.sv
// Shared types, constants and helper functions for the form field extractor.
// No dependencies; imported by ffpd_parser and the top level.
package ffpd_pkg;

  localparam int unsigned NameLen = 7;
  localparam logic [3:0] NoMatch = 4'd15;

  localparam logic [7:0] ChEquals = 8'h3D;  // '='
  localparam logic [7:0] ChAmp    = 8'h26;  // '&'
  localparam logic [7:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [7:0] ChPct    = 8'h25;  // '%'
  localparam logic [7:0] ChSpace  = 8'h20;  // ' '

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_e;

  typedef struct packed {
    logic       in_value;
    logic [3:0] name_match;
    logic       in_target;
    esc_e       esc;
    logic [3:0] high_nibble;
    logic       occ_nonempty;
    logic       occ_error;
  } state_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       restart;
    logic       done_res;
    status_e    status;
  } result_t;

  // Character of the field name "request" at a given position
  function automatic logic [7:0] name_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h72;  // r
      3'd1:    c = 8'h65;  // e
      3'd2:    c = 8'h71;  // q
      3'd3:    c = 8'h75;  // u
      3'd4:    c = 8'h65;  // e
      3'd5:    c = 8'h73;  // s
      3'd6:    c = 8'h74;  // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ffpd_parser.sv
// Parser state and one-byte decode step of the form field extractor.
// Depends on ffpd_pkg for the state and result types and the helpers.
module ffpd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  output ffpd_pkg::result_t res_o,
  output logic              emit_o
);
  import ffpd_pkg::*;

  state_t     state_q, state_d;
  result_t    res;
  logic [4:0] hex;
  logic       plain;

  // Work out next state and result for the item in the input register
  always_comb begin
    state_d  = state_q;
    res      = '0;
    res.status = ST_OK;
    hex      = hex_digit(data_byte_i);
    plain    = 1'b1;

    if (!state_q.in_value) begin
      // name phase: match against the field name up to '='
      if (data_byte_i == ChEquals) begin
        state_d.in_value = 1'b1;
        if (state_q.name_match == 4'(NameLen)) begin
          state_d.in_target    = 1'b1;
          res.restart          = 1'b1;
          state_d.occ_nonempty = 1'b0;
          state_d.occ_error    = 1'b0;
          state_d.esc          = ESC_NONE;
          state_d.high_nibble  = 4'd0;
        end
        state_d.name_match = 4'd0;
      end else if (state_q.name_match < 4'(NameLen) &&
                   data_byte_i == name_char(state_q.name_match[2:0])) begin
        state_d.name_match = state_q.name_match + 4'd1;
      end else begin
        state_d.name_match = NoMatch;
      end
    end else if (data_byte_i == ChAmp) begin
      // end of value: a pending escape is cut short
      if (state_q.in_target && state_q.esc != ESC_NONE) state_d.occ_error = 1'b1;
      state_d.in_value   = 1'b0;
      state_d.in_target  = 1'b0;
      state_d.esc        = ESC_NONE;
      state_d.name_match = 4'd0;
    end else if (state_q.in_target) begin
      state_d.occ_nonempty = 1'b1;
      if (state_q.esc == ESC_HIGH && hex[4]) begin
        state_d.high_nibble = hex[3:0];
        state_d.esc         = ESC_LOW;
        plain               = 1'b0;
      end else if (state_q.esc == ESC_LOW && hex[4]) begin
        res.out_byte = {state_q.high_nibble, hex[3:0]};
        res.has_byte = 1'b1;
        state_d.esc  = ESC_NONE;
        plain        = 1'b0;
      end else if (state_q.esc != ESC_NONE) begin
        // bad digit: drop the escape and treat the byte as plain
        state_d.occ_error = 1'b1;
        state_d.esc       = ESC_NONE;
      end
      if (plain) begin
        if (data_byte_i == ChPlus) begin
          res.out_byte = ChSpace;
          res.has_byte = 1'b1;
        end else if (data_byte_i == ChPct) begin
          state_d.esc = ESC_HIGH;
        end else begin
          res.out_byte = data_byte_i;
          res.has_byte = 1'b1;
        end
      end
    end

    // end of body: report status and start over
    if (last_byte_i) begin
      if (state_d.in_target && state_d.esc != ESC_NONE) state_d.occ_error = 1'b1;
      res.done_res = 1'b1;
      if (!state_d.occ_nonempty) begin
        res.status = ST_EMPTY;
      end else if (state_d.occ_error) begin
        res.status = ST_MALFORMED;
      end else begin
        res.status = ST_OK;
      end
      state_d = '0;
    end
  end

  assign res_o  = res;
  assign emit_o = res.has_byte | res.restart | res.done_res;

  // Advance state only when the item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

  // The final byte leaves the parser in its reset state
  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && last_byte_i |=> state_q == '0)
    else $error("parser state not cleared after final byte");

  // Escape stage never takes the unused code
  a_esc_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.esc != 2'd3)
    else $error("escape stage holds unused code");

  // Name match counter is a position in the name or the no-match mark
  a_match_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.name_match <= 4'(NameLen) || state_q.name_match == NoMatch)
    else $error("name match counter out of range");

endmodule

>>> hw/rtl/form_field_extract_percent_decode.sv
// Top level of the form field extractor: input register, parser, result register.
// Depends on ffpd_pkg and ffpd_parser.
//
//  channel  dir  tdata (low bit up)                 tuser (low bit up)     tlast
//  s_axis   in   data_byte[7:0]                     -                      last_byte
//  m_axis   out  out_byte[7:0], status[9:8], 0 pad  has_byte, restart      done_res
//
// One body byte per cycle, unless m_axis stalls a full result register while the
// item in the input register gives a result; that item then waits there. A result,
// if any, moves to the result register; bytes with no result leave no output item.
// Reset clears the parser state and both valid flags. A stall on m_axis holds
// the result register; the input register still drains items with no result.
module form_field_extract_percent_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_byte[7:0], status[9:8], zeros[15:10]
  output logic [1:0]  m_axis_tuser,   // has_byte[0], restart[1]
  output logic        m_axis_tlast
);
  import ffpd_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  result_t    out_res_q;
  result_t    res;
  logic       emit;
  logic       out_free;
  logic       advance;

  ffpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .res_o       (res),
    .emit_o      (emit)
  );

  // Handshake: move the item on when its result has somewhere to go
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.status, out_res_q.out_byte};
  assign m_axis_tuser  = {out_res_q.restart, out_res_q.has_byte};
  assign m_axis_tlast  = out_res_q.done_res;

  // Every output item carries a byte, a restart or the end of the body
  a_item_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tuser[1] || m_axis_tlast))
    else $error("output item with nothing to report");

  // Without a decoded byte the byte lane reads zero
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("byte lane set without has_byte");

  // Status is only reported on the final byte
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[9:8] == ST_OK)
    else $error("status set before end of body");

endmodule
